[design/swtq_pkg.sv]
`default_nettype none
package swtq_pkg;

  localparam int MaxResults = 16;
  localparam int CntW = $clog2(MaxResults);

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_CREATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] KIND_CREATED = 2'd0;
  localparam logic [1:0] KIND_FULL    = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_ACK     = 2'd3;

  typedef enum logic [1:0] {
    SCAN_MARK,
    SCAN_FIND,
    SCAN_REMOVE
  } scan_mode_t;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_NEW,
    ID_PEND
  } id_sel_t;

  typedef struct packed {
    logic       accept;
    logic       tick;
    logic       scan_go;
    scan_mode_t mode;
    logic       create;
    logic       commit;
    logic       emit;
    logic [1:0] kind;
    id_sel_t    id_sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_found;
    logic have_pend;
    logic cnt_last;
    logic full;
  } status_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] deadline;
    logic [23:0] period;
    logic        repeat_en;
  } entry_t;

endpackage
`default_nettype wire

[design/swtq_ctrl.sv]
`default_nettype none
module swtq_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire  [1:0]            opcode,
  input  swtq_pkg::status_t     status,
  output logic                  busy,
  output swtq_pkg::cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_REMOVE,
    S_MARK,
    S_FIND,
    S_DECIDE,
    S_FLUSH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.mode = swtq_pkg::SCAN_MARK;
    cmd.id_sel = swtq_pkg::ID_ZERO;
    cmd.kind = swtq_pkg::KIND_ACK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          priority if (opcode == swtq_pkg::OP_CREATE) begin
            state_next = S_CREATE;
          end else if (opcode == swtq_pkg::OP_REMOVE) begin
            cmd.scan_go = 1'b1;
            cmd.mode = swtq_pkg::SCAN_REMOVE;
            state_next = S_REMOVE;
          end else if (opcode == swtq_pkg::OP_TICK) begin
            cmd.tick = 1'b1;
            cmd.scan_go = 1'b1;
            cmd.mode = swtq_pkg::SCAN_MARK;
            state_next = S_MARK;
          end else begin
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
          end
        end
      end
      S_CREATE: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        if (status.full) begin
          cmd.kind = swtq_pkg::KIND_FULL;
        end else begin
          cmd.create = 1'b1;
          cmd.kind = swtq_pkg::KIND_CREATED;
          cmd.id_sel = swtq_pkg::ID_NEW;
        end
        state_next = S_IDLE;
      end
      S_REMOVE: begin
        if (status.scan_done) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MARK: begin
        if (status.scan_done) begin
          cmd.scan_go = 1'b1;
          cmd.mode = swtq_pkg::SCAN_FIND;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        if (status.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.best_found) begin
          // hold each expiry until the next search tells whether it is the last
          cmd.commit = 1'b1;
          cmd.emit = status.have_pend;
          cmd.kind = swtq_pkg::KIND_EXPIRED;
          cmd.id_sel = swtq_pkg::ID_PEND;
          if (status.cnt_last) begin
            state_next = S_FLUSH;
          end else begin
            cmd.scan_go = 1'b1;
            cmd.mode = swtq_pkg::SCAN_FIND;
            state_next = S_FIND;
          end
        end else begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (status.have_pend) begin
            cmd.kind = swtq_pkg::KIND_EXPIRED;
            cmd.id_sel = swtq_pkg::ID_PEND;
          end
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        cmd.emit = 1'b1;
        cmd.last = 1'b1;
        cmd.kind = swtq_pkg::KIND_EXPIRED;
        cmd.id_sel = swtq_pkg::ID_PEND;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/swtq_dp.sv]
`default_nettype none
module swtq_dp #(
  parameter int SLOTS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  swtq_pkg::cmd_t      cmd,
  input  wire  [23:0]         wait_ms,
  input  wire                 periodic,
  input  wire  [31:0]         target_id,
  output swtq_pkg::status_t   status,
  output logic                strobe,
  output logic [1:0]          kind,
  output logic [31:0]         timer_id,
  output logic                last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(SLOTS - 1);

  swtq_pkg::entry_t mem [SLOTS];
  swtq_pkg::entry_t rdata;
  swtq_pkg::entry_t best;
  swtq_pkg::entry_t wdata;

  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  due;
  logic [31:0]       now_ms;
  logic [31:0]       next_id;
  logic [23:0]       wait_q;
  logic              per_q;
  logic [31:0]       target_q;
  swtq_pkg::scan_mode_t mode;
  logic              scan_act;
  logic [IW-1:0]     scan_idx;
  logic              rd_vld;
  logic [IW-1:0]     rd_idx;
  logic              best_found;
  logic [IW-1:0]     best_idx;
  logic              have_pend;
  logic [31:0]       pend_id;
  logic [swtq_pkg::CntW-1:0] cnt;
  logic [IW-1:0]     free_idx;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [31:0]       diff;
  logic [23:0]       step;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign step = (best.period == 24'd0) ? 24'd1 : best.period;
  assign diff = now_ms - rdata.deadline;

  always_comb begin
    we = 1'b0;
    waddr = best_idx;
    wdata = best;
    if (cmd.create) begin
      we = 1'b1;
      waddr = free_idx;
      wdata.ident = next_id;
      wdata.deadline = now_ms + {8'd0, wait_q} + 32'd1;
      wdata.period = wait_q;
      wdata.repeat_en = per_q;
    end else if (cmd.commit && best.repeat_en) begin
      we = 1'b1;
      wdata.deadline = best.deadline + {8'd0, step};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      due <= '0;
      now_ms <= '0;
      next_id <= '0;
      scan_act <= 1'b0;
      scan_idx <= '0;
      rd_vld <= 1'b0;
      best_found <= 1'b0;
      have_pend <= 1'b0;
      cnt <= '0;
      strobe <= 1'b0;
      mode <= swtq_pkg::SCAN_MARK;
    end else begin
      if (cmd.accept) begin
        wait_q <= wait_ms;
        per_q <= periodic;
        target_q <= target_id;
        have_pend <= 1'b0;
        cnt <= '0;
      end
      if (cmd.tick) begin
        now_ms <= now_ms + 32'd1;
      end

      // slot scan: one read issued per cycle, its data in the cycle after
      rd_vld <= scan_act;
      rd_idx <= scan_idx;
      if (cmd.scan_go) begin
        scan_act <= 1'b1;
        scan_idx <= '0;
        mode <= cmd.mode;
        best_found <= 1'b0;
      end else if (scan_act) begin
        if (scan_idx == LastIdx) begin
          scan_act <= 1'b0;
        end else begin
          scan_idx <= scan_idx + IW'(1);
        end
      end

      if (rd_vld) begin
        unique case (mode)
          swtq_pkg::SCAN_MARK: begin
            due[rd_idx] <= valid[rd_idx] && !diff[31];
          end
          swtq_pkg::SCAN_FIND: begin
            // strict compare keeps the lower slot on equal ids
            if (due[rd_idx] && (!best_found || rdata.ident < best.ident)) begin
              best_found <= 1'b1;
              best <= rdata;
              best_idx <= rd_idx;
            end
          end
          swtq_pkg::SCAN_REMOVE: begin
            if (valid[rd_idx] && rdata.ident == target_q) begin
              valid[rd_idx] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.create) begin
        valid[free_idx] <= 1'b1;
        next_id <= next_id + 32'd1;
      end
      if (cmd.commit) begin
        due[best_idx] <= 1'b0;
        if (!best.repeat_en) begin
          valid[best_idx] <= 1'b0;
        end
        pend_id <= best.ident;
        have_pend <= 1'b1;
        cnt <= cnt + swtq_pkg::CntW'(1);
      end

      strobe <= cmd.emit;
      if (cmd.emit) begin
        kind <= cmd.kind;
        last <= cmd.last;
        unique case (cmd.id_sel)
          swtq_pkg::ID_NEW:  timer_id <= next_id;
          swtq_pkg::ID_PEND: timer_id <= pend_id;
          default:           timer_id <= '0;
        endcase
      end
    end
  end

  assign status.scan_done = rd_vld && (rd_idx == LastIdx);
  assign status.best_found = best_found;
  assign status.have_pend = have_pend;
  assign status.cnt_last = (cnt == swtq_pkg::CntW'(swtq_pkg::MaxResults - 1));
  assign status.full = &valid;

endmodule
`default_nettype wire

[design/software_timer_queue_unit.sv]
`default_nettype none
// software timer queue: a table of SLOTS millisecond timers.
// command port: opcode, wait_ms, periodic and target_id are taken when
// start is high and busy is low. opcode 0 advances time by one tick and
// reports due timers, 1 creates a timer, 2 removes timers by id.
// result port: strobe marks one result per cycle on kind, timer_id, last;
// last is set on the final result of each item. results cannot be held off.
// a create is answered from the S_CREATE state; a remove takes one pass
// over the slots; a tick takes one mark pass plus one search pass per
// expiry reported (up to 16) and, below that cap, one more that finds
// none. the passes read the slot memory one entry per cycle through its
// single read port. an item with an unused opcode is acknowledged in the
// cycle after acceptance. items are handled one at a time; busy stays
// high until the last result is registered for output and is low in the
// cycle that it is presented. a new item may be accepted in the cycle that
// the final result of the previous one is presented.
// reset clears time, the id counter and all slots at once.
module software_timer_queue_unit #(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  opcode,
  input  wire  [23:0] wait_ms,
  input  wire         periodic,
  input  wire  [31:0] target_id,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [31:0] timer_id,
  output logic        last
);

  swtq_pkg::cmd_t    cmd;
  swtq_pkg::status_t status;

  swtq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  swtq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wait_ms   (wait_ms),
    .periodic  (periodic),
    .target_id (target_id),
    .status    (status),
    .strobe    (strobe),
    .kind      (kind),
    .timer_id  (timer_id),
    .last      (last)
  );

endmodule
`default_nettype wire

[design/swtq_checker.sv]
`default_nettype none
module swtq_checker (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        strobe,
  input wire [1:0]  kind,
  input wire [31:0] timer_id,
  input wire        last
);

  // every accepted item is either still in work or answered next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || strobe))
    else $error("accepted item neither busy nor answered");

  // only expiries can be followed by further results of the same item
  a_nonlast_expired: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> (kind == swtq_pkg::KIND_EXPIRED))
    else $error("non-final result is not an expiry");

  a_nonlast_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("non-final result while idle");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == swtq_pkg::KIND_FULL || kind == swtq_pkg::KIND_ACK))
      |-> (timer_id == 32'd0 && last))
    else $error("refusal or acknowledge carries an id or is not final");

endmodule

bind software_timer_queue_unit swtq_checker u_swtq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .kind     (kind),
  .timer_id (timer_id),
  .last     (last)
);
`default_nettype wire
